### rtl/core/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, pipeline transaction types and tables for the swept
// circle collision pipeline.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = 16;
  localparam int ANG_OUT_W  = 16;
  localparam int TIME_W     = 32;
  localparam int COORD_W    = 33;
  localparam int WW_W       = 66;
  localparam int WD_W       = 67;
  localparam int RAD_W      = 132;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int VEC_W      = 51;
  localparam int NORM_W     = 30;
  localparam int NORM_STEPS = 5;
  localparam int CRD_STAGES = 30;
  localparam int CRD_IDX_W  = 5;
  localparam int ACC_W      = 32;
  localparam int IN_W       = 352;
  localparam int OUT_W      = 48;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [DATA_W-1:0] THR_RESET = 32'd4295;
  localparam logic              REG_THR   = 1'b0;

  typedef struct packed {
    logic                     par;
    logic                     par_hit;
    logic                     rad_ok;
    logic signed [WD_W-1:0]   wd;
    logic [WW_W-1:0]          ww;
    logic [TIME_W-1:0]        hor;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sqrt_tok_t;

  typedef struct packed {
    logic              ok;
    logic [TIME_W-1:0] nlo;
    logic [WW_W-1:0]   rem;
    logic [TIME_W-1:0] q;
    side_t             side;
  } div_tok_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic                    par;
    logic                    hit;
    logic [TIME_W-1:0]       tq;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ACC_W-1:0]          acc;
    logic                      zero;
    logic                      par;
    logic                      hit;
    logic [TIME_W-1:0]         tq;
  } crd_tok_t;

  typedef struct packed {
    logic                 hit;
    logic [TIME_W-1:0]    tq;
    logic [ANG_OUT_W-1:0] ang;
  } res_t;

  function automatic logic fits(input logic signed [VEC_W-1:0] v, input int unsigned n);
    logic signed [VEC_W-1:0] s;
    s = v >>> (n - 1);
    return (s == '0) || (s == '1);
  endfunction

  function automatic logic [ACC_W-1:0] atan_turn(input logic [CRD_IDX_W-1:0] idx);
    logic [ACC_W-1:0] t;
    case (idx)
      5'd0:    t = 32'h20000000;
      5'd1:    t = 32'h12E4051D;
      5'd2:    t = 32'h09FB385B;
      5'd3:    t = 32'h051111D4;
      5'd4:    t = 32'h028B0D43;
      5'd5:    t = 32'h0145D7E1;
      5'd6:    t = 32'h00A2F61E;
      5'd7:    t = 32'h00517C55;
      5'd8:    t = 32'h0028BE53;
      5'd9:    t = 32'h00145F2E;
      5'd10:   t = 32'h000A2F98;
      5'd11:   t = 32'h000517CC;
      5'd12:   t = 32'h00028BE6;
      5'd13:   t = 32'h000145F3;
      5'd14:   t = 32'h0000A2F9;
      5'd15:   t = 32'h0000517C;
      5'd16:   t = 32'h000028BE;
      5'd17:   t = 32'h0000145F;
      5'd18:   t = 32'h00000A2F;
      5'd19:   t = 32'h00000517;
      5'd20:   t = 32'h0000028B;
      5'd21:   t = 32'h00000145;
      5'd22:   t = 32'h000000A2;
      5'd23:   t = 32'h00000051;
      5'd24:   t = 32'h00000028;
      5'd25:   t = 32'h00000014;
      5'd26:   t = 32'h0000000A;
      5'd27:   t = 32'h00000005;
      5'd28:   t = 32'h00000002;
      5'd29:   t = 32'h00000001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/scc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// scc_sqrt_cell
// One root digit of the integer square root chain.
// ----------------------------------------------------------------------------
module scc_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              up_vld,
  input  scc_pkg::sqrt_tok_t up_tok,
  output logic              dn_vld,
  output scc_pkg::sqrt_tok_t dn_tok
);

  logic               vld_r;
  scc_pkg::sqrt_tok_t tok_r, tok_nxt;
  logic [scc_pkg::SREM_W+1:0] rem2, trial, diff;
  logic ge;

  always_comb begin
    rem2  = {up_tok.rem, up_tok.rad[scc_pkg::RAD_W-1 -: 2]};
    trial = {2'b00, up_tok.root, 2'b01};
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
    tok_nxt      = up_tok;
    tok_nxt.rad  = up_tok.rad << 2;
    tok_nxt.rem  = ge ? diff[scc_pkg::SREM_W-1:0] : rem2[scc_pkg::SREM_W-1:0];
    tok_nxt.root = {up_tok.root[scc_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_tok = tok_r;

endmodule

### rtl/core/scc_div_cell.sv
// ----------------------------------------------------------------------------
// scc_div_cell
// One quotient bit of the restoring contact time divider chain.
// ----------------------------------------------------------------------------
module scc_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             up_vld,
  input  scc_pkg::div_tok_t up_tok,
  output logic             dn_vld,
  output scc_pkg::div_tok_t dn_tok
);

  logic              vld_r;
  scc_pkg::div_tok_t tok_r, tok_nxt;
  logic [scc_pkg::WW_W:0] r2, dvs, diff;
  logic ge;

  always_comb begin
    r2   = {up_tok.rem, up_tok.nlo[scc_pkg::TIME_W-1]};
    dvs  = {1'b0, up_tok.side.ww};
    diff = r2 - dvs;
    ge   = (r2 >= dvs);
    tok_nxt     = up_tok;
    tok_nxt.nlo = up_tok.nlo << 1;
    tok_nxt.rem = ge ? diff[scc_pkg::WW_W-1:0] : r2[scc_pkg::WW_W-1:0];
    tok_nxt.q   = {up_tok.q[scc_pkg::TIME_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_tok = tok_r;

endmodule

### rtl/core/scc_cordic_cell.sv
// ----------------------------------------------------------------------------
// scc_cordic_cell
// One vectoring micro-rotation of the contact angle chain.
// ----------------------------------------------------------------------------
module scc_cordic_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic [scc_pkg::CRD_IDX_W-1:0]    stage,
  input  logic                             up_vld,
  input  scc_pkg::crd_tok_t                up_tok,
  output logic                             dn_vld,
  output scc_pkg::crd_tok_t                dn_tok
);

  logic              vld_r;
  scc_pkg::crd_tok_t tok_r, tok_nxt;
  logic signed [scc_pkg::COORD_W-1:0] xs, ys;
  logic [scc_pkg::ACC_W-1:0] at;

  always_comb begin
    xs = up_tok.x >>> stage;
    ys = up_tok.y >>> stage;
    at = scc_pkg::atan_turn(stage);
    tok_nxt = up_tok;
    if (up_tok.y[scc_pkg::COORD_W-1]) begin
      tok_nxt.x   = up_tok.x - ys;
      tok_nxt.y   = up_tok.y + xs;
      tok_nxt.acc = up_tok.acc - at;
    end else begin
      tok_nxt.x   = up_tok.x + ys;
      tok_nxt.y   = up_tok.y - xs;
      tok_nxt.acc = up_tok.acc + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_tok = tok_r;

endmodule

### rtl/core/swept_circle_collision.sv
// ----------------------------------------------------------------------------
// swept_circle_collision
// Swept circle pair contact test: hit flag, first contact time and angle.
// ----------------------------------------------------------------------------
// One circle pair is accepted per clock while in_tready is high. The pipeline
// is built from six front stages of exact products, 66 square root cells,
// 32 divider cells, the angle vector and its five-step normalisation, and 30
// cordic cells. A two-entry output buffer lets the input keep flowing while
// one result waits; only when both entries are held does the whole pipeline
// pause and in_tready fall.
module swept_circle_collision (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos_x_a, pos_y_a, vel_x_a, vel_y_a, radius_a, pos_x_b, pos_y_b, vel_x_b,
  // vel_y_b, radius_b, horizon, zero pad
  input  logic [scc_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // contact_time, contact_angle
  output logic [scc_pkg::OUT_W-1:0]     out_tdata,
  // hit
  output logic [0:0]                    out_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scc_pkg::ADDR_W-1:0]    paddr,
  input  logic [scc_pkg::DATA_W-1:0]    pwdata,
  output logic [scc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int PW = scc_pkg::RAD_W + 1;

  logic en, push, pop;
  logic [1:0] cnt_r, cnt_nxt;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  // configuration
  logic [scc_pkg::DATA_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= scc_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == scc_pkg::REG_THR)) begin
      thr_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == scc_pkg::REG_THR) ? thr_r : '0;

  // stage 1: relative motion
  logic s1_vld_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_wx_r, s1_wy_r;
  logic [31:0] s1_rr_r, s1_hor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r  <= $signed({in_tdata[31], in_tdata[31:0]})
                - $signed({in_tdata[190], in_tdata[190:159]});
      s1_dy_r  <= $signed({in_tdata[63], in_tdata[63:32]})
                - $signed({in_tdata[222], in_tdata[222:191]});
      s1_wx_r  <= $signed({in_tdata[95], in_tdata[95:64]})
                - $signed({in_tdata[254], in_tdata[254:223]});
      s1_wy_r  <= $signed({in_tdata[127], in_tdata[127:96]})
                - $signed({in_tdata[286], in_tdata[286:255]});
      s1_rr_r  <= {1'b0, in_tdata[158:128]} + {1'b0, in_tdata[317:287]};
      s1_hor_r <= in_tdata[349:318];
    end
  end

  // stage 2: products
  logic s2_vld_r;
  logic [63:0] s2_r2_r;
  logic signed [65:0] s2_wxwx_r, s2_wywy_r, s2_wxdx_r, s2_wydy_r;
  logic signed [65:0] s2_wxdy_r, s2_wydx_r, s2_dxdx_r, s2_dydy_r;
  logic signed [32:0] s2_dx_r, s2_dy_r, s2_wx_r, s2_wy_r;
  logic [31:0] s2_hor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r2_r   <= s1_rr_r * s1_rr_r;
      s2_wxwx_r <= s1_wx_r * s1_wx_r;
      s2_wywy_r <= s1_wy_r * s1_wy_r;
      s2_wxdx_r <= s1_wx_r * s1_dx_r;
      s2_wydy_r <= s1_wy_r * s1_dy_r;
      s2_wxdy_r <= s1_wx_r * s1_dy_r;
      s2_wydx_r <= s1_wy_r * s1_dx_r;
      s2_dxdx_r <= s1_dx_r * s1_dx_r;
      s2_dydy_r <= s1_dy_r * s1_dy_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_wx_r   <= s1_wx_r;
      s2_wy_r   <= s1_wy_r;
      s2_hor_r  <= s1_hor_r;
    end
  end

  // stage 3: dot, cross and squared lengths
  logic s3_vld_r;
  scc_pkg::side_t s3_side_r, s3_side_nxt;
  logic [63:0] s3_r2_r;
  logic [65:0] s3_cra_r, s3_cra_nxt;
  logic [65:0] ww3, dd3;
  logic signed [66:0] cr3, crn3;

  always_comb begin
    ww3  = 66'(s2_wxwx_r) + 66'(s2_wywy_r);
    dd3  = 66'(s2_dxdx_r) + 66'(s2_dydy_r);
    cr3  = $signed({s2_wxdy_r[65], s2_wxdy_r}) - $signed({s2_wydx_r[65], s2_wydx_r});
    crn3 = -cr3;
    s3_cra_nxt          = cr3[66] ? crn3[65:0] : cr3[65:0];
    s3_side_nxt.par     = !(ww3 > {34'd0, thr_r});
    s3_side_nxt.par_hit = (dd3 < {2'b00, s2_r2_r});
    s3_side_nxt.rad_ok  = 1'b0;
    s3_side_nxt.wd      = $signed({s2_wxdx_r[65], s2_wxdx_r})
                        + $signed({s2_wydy_r[65], s2_wydy_r});
    s3_side_nxt.ww      = ww3;
    s3_side_nxt.hor     = s2_hor_r;
    s3_side_nxt.dx      = s2_dx_r;
    s3_side_nxt.dy      = s2_dy_r;
    s3_side_nxt.wx      = s2_wx_r;
    s3_side_nxt.wy      = s2_wy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
      s3_r2_r   <= s2_r2_r;
      s3_cra_r  <= s3_cra_nxt;
    end
  end

  // stage 4: partial products of R^2 |w|^2 and cross^2
  logic s4_vld_r;
  scc_pkg::side_t s4_side_r;
  logic [63:0] s4_p00_r, s4_p10_r;
  logic [65:0] s4_p01_r, s4_p11_r, s4_c00_r, s4_c01_r, s4_c11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s3_side_r;
      s4_p00_r  <= s3_r2_r[31:0] * s3_side_r.ww[31:0];
      s4_p01_r  <= s3_r2_r[31:0] * s3_side_r.ww[65:32];
      s4_p10_r  <= s3_r2_r[63:32] * s3_side_r.ww[31:0];
      s4_p11_r  <= s3_r2_r[63:32] * s3_side_r.ww[65:32];
      s4_c00_r  <= s3_cra_r[32:0] * s3_cra_r[32:0];
      s4_c01_r  <= s3_cra_r[32:0] * s3_cra_r[65:33];
      s4_c11_r  <= s3_cra_r[65:33] * s3_cra_r[65:33];
    end
  end

  // stage 5: sum partial products
  logic s5_vld_r;
  scc_pkg::side_t s5_side_r;
  logic [PW-1:0] s5_a_r, s5_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side_r <= s4_side_r;
      s5_a_r    <= PW'(s4_p00_r) + (PW'(s4_p01_r) << 32) + (PW'(s4_p10_r) << 32)
                 + (PW'(s4_p11_r) << 64);
      s5_c_r    <= PW'(s4_c00_r) + (PW'(s4_c01_r) << 34) + (PW'(s4_c11_r) << 66);
    end
  end

  // stage 6: radicand
  logic [PW-1:0] rad6;
  logic rad_ok6;
  scc_pkg::sqrt_tok_t sq_tok [scc_pkg::ROOT_W+1];
  logic               sq_vld [scc_pkg::ROOT_W+1];
  scc_pkg::sqrt_tok_t s6_tok_r, s6_tok_nxt;
  logic s6_vld_r;

  always_comb begin
    rad6    = s5_a_r - s5_c_r;
    rad_ok6 = !rad6[PW-1] && (rad6 != '0);
    s6_tok_nxt             = '0;
    s6_tok_nxt.rad         = rad_ok6 ? rad6[scc_pkg::RAD_W-1:0] : '0;
    s6_tok_nxt.side        = s5_side_r;
    s6_tok_nxt.side.rad_ok = rad_ok6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tok_r <= s6_tok_nxt;
    end
  end

  assign sq_tok[0] = s6_tok_r;
  assign sq_vld[0] = s6_vld_r;

  for (genvar g = 0; g < scc_pkg::ROOT_W; g++) begin : g_sqrt
    scc_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .up_vld (sq_vld[g]),
      .up_tok (sq_tok[g]),
      .dn_vld (sq_vld[g+1]),
      .dn_tok (sq_tok[g+1])
    );
  end

  // stage 7: numerator and divider set-up
  localparam int NUM_W = scc_pkg::WD_W + 2;
  localparam int NSH_W = NUM_W + scc_pkg::FRAC_BITS;
  logic signed [NUM_W-1:0] sum7, num7;
  logic [NSH_W-1:0] nsh7;
  logic [scc_pkg::WW_W-1:0] hi7;
  scc_pkg::div_tok_t dv_tok [scc_pkg::TIME_W+1];
  logic              dv_vld [scc_pkg::TIME_W+1];
  scc_pkg::div_tok_t s7_tok_r, s7_tok_nxt;
  logic s7_vld_r;

  always_comb begin
    sum7 = NUM_W'(sq_tok[scc_pkg::ROOT_W].side.wd)
         + $signed({3'b000, sq_tok[scc_pkg::ROOT_W].root});
    num7 = -sum7;
    nsh7 = {num7, {scc_pkg::FRAC_BITS{1'b0}}};
    hi7  = scc_pkg::WW_W'(nsh7[NSH_W-1:scc_pkg::TIME_W]);
    s7_tok_nxt      = '0;
    s7_tok_nxt.side = sq_tok[scc_pkg::ROOT_W].side;
    s7_tok_nxt.ok   = sq_tok[scc_pkg::ROOT_W].side.rad_ok && !num7[NUM_W-1]
                    && (hi7 < sq_tok[scc_pkg::ROOT_W].side.ww);
    s7_tok_nxt.nlo  = nsh7[scc_pkg::TIME_W-1:0];
    s7_tok_nxt.rem  = hi7;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= sq_vld[scc_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_tok_r <= s7_tok_nxt;
    end
  end

  assign dv_tok[0] = s7_tok_r;
  assign dv_vld[0] = s7_vld_r;

  for (genvar g = 0; g < scc_pkg::TIME_W; g++) begin : g_div
    scc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .up_vld (dv_vld[g]),
      .up_tok (dv_tok[g]),
      .dn_vld (dv_vld[g+1]),
      .dn_tok (dv_tok[g+1])
    );
  end

  // stage 8: horizon check and displacement products
  scc_pkg::div_tok_t dv_last;
  logic s8_vld_r, s8_hit_r;
  scc_pkg::side_t s8_side_r;
  logic [31:0] s8_q_r;
  logic signed [65:0] s8_px_r, s8_py_r;

  assign dv_last = dv_tok[scc_pkg::TIME_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= dv_vld[scc_pkg::TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side_r <= dv_last.side;
      s8_q_r    <= dv_last.q;
      s8_hit_r  <= dv_last.ok && (dv_last.q <= dv_last.side.hor);
      s8_px_r   <= dv_last.side.wx * $signed({1'b0, dv_last.q});
      s8_py_r   <= dv_last.side.wy * $signed({1'b0, dv_last.q});
    end
  end

  // stage 9: separation vector at contact, or at start for parallel pairs
  scc_pkg::vec_t nm_r [scc_pkg::NORM_STEPS+1];
  logic          nm_vld_r [scc_pkg::NORM_STEPS+1];
  scc_pkg::vec_t v9;
  logic signed [65:0] sx9, sy9;

  always_comb begin
    sx9 = (s8_px_r >>> scc_pkg::FRAC_BITS) + 66'(s8_side_r.dx);
    sy9 = (s8_py_r >>> scc_pkg::FRAC_BITS) + 66'(s8_side_r.dy);
    v9.par = s8_side_r.par;
    if (s8_side_r.par) begin
      v9.x   = scc_pkg::VEC_W'(s8_side_r.dx);
      v9.y   = scc_pkg::VEC_W'(s8_side_r.dy);
      v9.hit = s8_side_r.par_hit;
      v9.tq  = '0;
    end else begin
      v9.x   = sx9[scc_pkg::VEC_W-1:0];
      v9.y   = sy9[scc_pkg::VEC_W-1:0];
      v9.hit = s8_hit_r;
      v9.tq  = s8_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r[0] <= 1'b0;
    end else if (en) begin
      nm_vld_r[0] <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_r[0] <= v9;
    end
  end

  // normalisation, one binary weight of the shift per step
  for (genvar k = 1; k <= scc_pkg::NORM_STEPS; k++) begin : g_norm
    localparam int SH = 1 << (scc_pkg::NORM_STEPS - k);
    localparam int FW = scc_pkg::NORM_W + SH - 1;
    scc_pkg::vec_t vn;
    logic big;

    always_comb begin
      big = !(scc_pkg::fits(nm_r[k-1].x, FW) && scc_pkg::fits(nm_r[k-1].y, FW));
      vn  = nm_r[k-1];
      if (big) begin
        vn.x = nm_r[k-1].x >>> SH;
        vn.y = nm_r[k-1].y >>> SH;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nm_vld_r[k] <= 1'b0;
      end else if (en) begin
        nm_vld_r[k] <= nm_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm_r[k] <= vn;
      end
    end
  end

  // quadrant pre-rotation
  scc_pkg::crd_tok_t cr_tok [scc_pkg::CRD_STAGES+1];
  logic              cr_vld [scc_pkg::CRD_STAGES+1];
  scc_pkg::crd_tok_t pr_tok_r, pr_nxt;
  logic pr_vld_r;
  logic signed [scc_pkg::COORD_W-1:0] xn, yn;

  always_comb begin
    xn = scc_pkg::COORD_W'($signed(nm_r[scc_pkg::NORM_STEPS].x[scc_pkg::NORM_W-1:0]));
    yn = scc_pkg::COORD_W'($signed(nm_r[scc_pkg::NORM_STEPS].y[scc_pkg::NORM_W-1:0]));
    pr_nxt.zero = (xn == '0) && (yn == '0);
    pr_nxt.par  = nm_r[scc_pkg::NORM_STEPS].par;
    pr_nxt.hit  = nm_r[scc_pkg::NORM_STEPS].hit;
    pr_nxt.tq   = nm_r[scc_pkg::NORM_STEPS].tq;
    pr_nxt.x    = xn;
    pr_nxt.y    = yn;
    pr_nxt.acc  = '0;
    if (xn[scc_pkg::COORD_W-1]) begin
      if (!yn[scc_pkg::COORD_W-1]) begin
        pr_nxt.x   = yn;
        pr_nxt.y   = -xn;
        pr_nxt.acc = 32'h4000_0000;
      end else begin
        pr_nxt.x   = -yn;
        pr_nxt.y   = xn;
        pr_nxt.acc = 32'hC000_0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else if (en) begin
      pr_vld_r <= nm_vld_r[scc_pkg::NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_tok_r <= pr_nxt;
    end
  end

  assign cr_tok[0] = pr_tok_r;
  assign cr_vld[0] = pr_vld_r;

  for (genvar g = 0; g < scc_pkg::CRD_STAGES; g++) begin : g_cordic
    scc_cordic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .stage  (scc_pkg::CRD_IDX_W'(g)),
      .up_vld (cr_vld[g]),
      .up_tok (cr_tok[g]),
      .dn_vld (cr_vld[g+1]),
      .dn_tok (cr_tok[g+1])
    );
  end

  // result formatting
  scc_pkg::crd_tok_t cl;
  scc_pkg::res_t res_new;
  logic [scc_pkg::ACC_W-1:0] acc0, acc1, rnd, angf;

  assign cl = cr_tok[scc_pkg::CRD_STAGES];

  always_comb begin
    acc0 = cl.zero ? '0 : cl.acc;
    acc1 = cl.par ? acc0 + (scc_pkg::ACC_W'(1) << (scc_pkg::ACC_W - 2)) : acc0;
    rnd  = acc1 + (scc_pkg::ACC_W'(1) << (scc_pkg::ACC_W - 1 - scc_pkg::ANGLE_BITS));
    angf = rnd >> (scc_pkg::ACC_W - scc_pkg::ANGLE_BITS);
    res_new.hit = cl.hit;
    res_new.tq  = cl.hit ? cl.tq : '0;
    res_new.ang = cl.hit ? angf[scc_pkg::ANG_OUT_W-1:0] : '0;
  end

  // two-entry output buffer
  scc_pkg::res_t ent0_r, ent1_r, ent0_nxt, ent1_nxt;

  assign push = en && cr_vld[scc_pkg::CRD_STAGES];
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    if (pop) begin
      ent0_nxt = ent1_r;
    end
    if (push) begin
      if ((cnt_r == 2'd0) || pop) begin
        ent0_nxt = res_new;
      end else begin
        ent1_nxt = res_new;
      end
    end
    cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  assign out_tvalid   = (cnt_r != 2'd0);
  assign out_tdata    = {ent0_r.ang, ent0_r.tq};
  assign out_tuser[0] = ent0_r.hit;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("result without contact carries data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cr_vld[scc_pkg::CRD_STAGES]))
    else $error("pipeline moved while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("full output buffer changed without a read");

endmodule

### sim/swept_circle_collision_chk.sv
// ----------------------------------------------------------------------------
// swept_circle_collision_chk
// Watches the pair and result streams and the register port, predicts the
// hit flag, contact time and contact angle of every accepted pair, and
// compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module swept_circle_collision_chk (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [scc_pkg::IN_W-1:0]   in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [scc_pkg::OUT_W-1:0]  out_tdata,
  input  logic [0:0]                 out_tuser,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scc_pkg::ADDR_W-1:0] paddr,
  input  logic [scc_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         errors,
  output int                         pending,
  output int                         hits,
  output int                         parallel_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] ctime;
    logic [15:0] angle;
    logic        par;
  } contact_t;

  localparam logic [31:0] ATAN_TURN [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  logic [31:0] speed_thr;
  contact_t    contacts_due[$];

  function automatic logic [31:0] vector_turn(wide_t x, wide_t y);
    wide_t       lim;
    longint      vx, vy, nx, ny, t;
    logic [31:0] acc;
    lim = wide_t'(1) <<< 29;
    while (x >= lim || x < -lim || y >= lim || y < -lim) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    vx = x[63:0];
    vy = y[63:0];
    acc = '0;
    if (vx == 0 && vy == 0) return '0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; acc = 32'h40000000;
      end else begin
        vx = -vy; vy = t; acc = 32'hC0000000;
      end
    end
    for (int i = 0; i < 30; i++) begin
      if (vy < 0) begin
        nx = vx - (vy >>> i); ny = vy + (vx >>> i); acc = acc - ATAN_TURN[i];
      end else begin
        nx = vx + (vy >>> i); ny = vy - (vx >>> i); acc = acc + ATAN_TURN[i];
      end
      vx = nx;
      vy = ny;
    end
    return acc;
  endfunction

  function automatic logic [15:0] binary_angle(logic [31:0] acc);
    logic [31:0] r;
    r = acc + 32'h00008000;
    return r[31:16];
  endfunction

  function automatic wide_t floor_root(wide_t v);
    wide_t r, c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(logic [scc_pkg::IN_W-1:0] d);
    logic signed [31:0] pxa, pya, vxa, vya, pxb, pyb, vxb, vyb;
    logic [30:0]        ra, rb;
    logic [31:0]        hor;
    wide_t              dx, dy, wx, wy, rr, r2, ww, wd, cr, rad, num, q, thr, hw;
    contact_t           c;
    {hor, rb, vyb, vxb, pyb, pxb, ra, vya, vxa, pya, pxa} = d[349:0];
    dx = wide_t'(pxa) - wide_t'(pxb);
    dy = wide_t'(pya) - wide_t'(pyb);
    wx = wide_t'(vxa) - wide_t'(vxb);
    wy = wide_t'(vya) - wide_t'(vyb);
    rr = ra;
    rr = rr + rb;
    r2 = rr * rr;
    ww = wx * wx + wy * wy;
    thr = speed_thr;
    hw = hor;
    c = '0;
    if (ww > thr) begin
      wd = wx * dx + wy * dy;
      cr = wx * dy - wy * dx;
      rad = r2 * ww - cr * cr;
      if (rad <= 0) return c;
      num = -(wd + floor_root(rad));
      if (num < 0) return c;
      q = (num <<< 16) / ww;
      if (q > hw) return c;
      c.hit = 1'b1;
      c.ctime = q[31:0];
      c.angle = binary_angle(vector_turn(dx + ((wx * q) >>> 16), dy + ((wy * q) >>> 16)));
    end else if (dx * dx + dy * dy < r2) begin
      c.hit = 1'b1;
      c.par = 1'b1;
      c.angle = binary_angle(vector_turn(dx, dy) + 32'h40000000);
    end
    return c;
  endfunction

  assign pending = contacts_due.size();

  always @(posedge clk) begin
    contact_t c;
    if (!rst_n) begin
      speed_thr <= scc_pkg::THR_RESET;
      errors <= 0;
      hits <= 0;
      parallel_hits <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {scc_pkg::REG_THR, 2'b00})
        speed_thr <= pwdata;
      if (in_tvalid && in_tready) begin
        c = predict_contact(in_tdata);
        contacts_due.push_back(c);
        if (c.hit) hits <= hits + 1;
        if (c.par) parallel_hits <= parallel_hits + 1;
      end
      if (out_tvalid && out_tready) begin
        if (contacts_due.size() == 0) begin
          $error("result with no pair outstanding");
          errors <= errors + 1;
        end else begin
          c = contacts_due.pop_front();
          if (out_tuser[0] !== c.hit || out_tdata[31:0] !== c.ctime ||
              out_tdata[47:32] !== c.angle) begin
            if (out_tuser[0] !== c.hit)
              $error("hit: expected %0d actual %0d", c.hit, out_tuser[0]);
            if (out_tdata[31:0] !== c.ctime)
              $error("contact_time: expected %h actual %h", c.ctime, out_tdata[31:0]);
            if (out_tdata[47:32] !== c.angle)
              $error("contact_angle: expected %h actual %h", c.angle, out_tdata[47:32]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### sim/swept_circle_collision_tb.sv
// ----------------------------------------------------------------------------
// swept_circle_collision_tb
// Drives circle pairs through the collision pipeline under random flow
// control and several speed thresholds, and reports the verdict of the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module swept_circle_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;
  localparam int N_PHASES = 5;
  localparam int PHASE_PAIRS = 230;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [scc_pkg::IN_W-1:0]   in_tdata;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [scc_pkg::OUT_W-1:0]  out_tdata;
  logic [0:0]                 out_tuser;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [scc_pkg::ADDR_W-1:0] paddr;
  logic [scc_pkg::DATA_W-1:0] pwdata;
  logic [scc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int  errors, pending, hits, parallel_hits;
  int  pairs_sent;
  bit  no_gaps;
  bit  hold_req;

  swept_circle_collision u_dut (.*);

  swept_circle_collision_chk u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .hits, .parallel_hits
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [scc_pkg::IN_W-1:0] pack_pair(
      int pxa, int pya, int vxa, int vya, int unsigned ra,
      int pxb, int pyb, int vxb, int vyb, int unsigned rb, int unsigned hor);
    return {2'b00, hor, rb[30:0], vyb, vxb, pyb, pxb, ra[30:0], vya, vxa, pya, pxa};
  endfunction

  function automatic int srand(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  function automatic logic [scc_pkg::IN_W-1:0] random_pair();
    int          pxa, pya, vxa, vya, dpx, dpy;
    int unsigned mode, hor;
    logic [scc_pkg::IN_W-1:0] d;
    mode = $urandom_range(9);
    pxa = srand(1 << 22);
    pya = srand(1 << 22);
    vxa = srand(1 << 18);
    vya = srand(1 << 18);
    dpx = srand(1 << 21);
    dpy = srand(1 << 21);
    hor = ($urandom_range(3) == 0) ? 32'hFFFFFFFF : $urandom_range(1 << 23);
    if (mode < 2) begin
      for (int i = 0; i < 11; i++) d[32*i +: 32] = $urandom;
      d[351:350] = 2'b00;
    end else if (mode < 4) begin
      d = pack_pair(pxa, pya, vxa, vya, $urandom_range(1 << 20), pxa + dpx, pya + dpy,
                    vxa + srand(2), vya + srand(2), $urandom_range(1 << 20), hor);
    end else begin
      // b sits ahead of a and moves back towards it
      d = pack_pair(pxa, pya, vxa, vya, $urandom_range(1 << 20), pxa + dpx, pya + dpy,
                    vxa - dpx / 8 + srand(1 << 16), vya - dpy / 8 + srand(1 << 16),
                    $urandom_range(1 << 20), hor);
    end
    return d;
  endfunction

  task automatic send_pair(logic [scc_pkg::IN_W-1:0] d);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    pairs_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_thr(logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {scc_pkg::REG_THR, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic directed_pairs();
    int m;
    m = 32'h7FFFFFFF;
    send_pair('0);
    send_pair(pack_pair(0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE));
    send_pair(pack_pair(3 * ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, 3 * ONE, ONE));
    send_pair(pack_pair(-10 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, 0, 20 * ONE));
    send_pair(pack_pair(-10 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE));
    send_pair(pack_pair(-10 * ONE, 2 * ONE, ONE, 0, ONE, 0, 0, 0, 0, ONE, 20 * ONE));
    send_pair(pack_pair(10 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 20 * ONE));
    send_pair(pack_pair(-2 * ONE, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 0));
    send_pair(pack_pair(0, 5 * ONE, 0, -ONE, ONE, 0, 0, 0, ONE, ONE, 32'hFFFFFFFF));
    send_pair(pack_pair(m, m, m, m, m, -m - 1, -m - 1, -m - 1, -m - 1, m, 32'hFFFFFFFF));
    send_pair(pack_pair(-m - 1, -m - 1, -m - 1, -m - 1, m, m, m, m, m, m, 32'hFFFFFFFF));
    send_pair(pack_pair(-m - 1, 0, m, 0, 0, m, 0, -m - 1, 0, 0, 32'hFFFFFFFF));
    send_pair(pack_pair(-ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0, ONE, 0));
  endtask

  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    logic [31:0] thr_set [N_PHASES];
    thr_set = '{32'd4295, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd0};
    thr_set[4] = $urandom;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pairs_sent = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) write_thr(thr_set[ph]);
      directed_pairs();
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        if (i % 60 == 0) no_gaps = ($urandom_range(3) == 0);
        if (ph == 1 && i == 20) hold_req = 1'b1;
        send_pair(random_pair());
      end
      drain();
    end
    $display("%0d pairs over %0d threshold settings, %0d contacts (%0d already overlapping)",
             pairs_sent, N_PHASES, hits, parallel_hits);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
